// ----- sv/bcfa_pkg.sv -----
package bcfa_pkg;

	// default geometry of the managed window
	localparam int unsigned FRAMES_DEF    = 4096;
	localparam int unsigned WORD_BITS_DEF = 32;

	// fixed field widths of the ports
	localparam int unsigned OP_W  = 1;
	localparam int unsigned CNT_W = 13;
	localparam int unsigned ALN_W = 13;
	localparam int unsigned FRM_W = 20;
	// physical frame arithmetic: base plus offset plus alignment slack
	localparam int unsigned PHYS_W = 21;

	localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
	localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

	localparam logic STAT_OK    = 1'b0;
	localparam logic STAT_NOMEM = 1'b1;

	// control group from the sequencer to the bitmap store
	typedef struct packed {
		logic rd;       // plain word read
		logic upd;      // read-modify-write of one word
		logic set_bits; // update sets the masked bits, else clears them
	} map_ctl_t;

	// alignment as a low-bit mask: highest set bit kept, zero taken as one
	function automatic logic [ALN_W-1:0] align_mask(input logic [ALN_W-1:0] a);
		logic [ALN_W-1:0] smear;
		smear = a;
		for (int i = 1; i < ALN_W; i++) begin
			smear = smear | (a >> i);
		end
		return smear >> 1;
	endfunction

endpackage

// ----- sv/bitmap_contiguous_frame_allocator_top.sv -----
// first-fit aligned page-frame allocator over a window of FRAMES frames that starts at the
// configured base_frame; the used/free bitmap lives in a one-port-read, one-port-write memory
// of ceil(FRAMES/WORD_BITS) words, first frame of a word in its msb. after reset a clearing
// pass writes every word to zero, one word per cycle, and no item is taken until it is done;
// base_frame writes are always taken. an allocation sets up, then walks the bitmap word by
// word while the candidate run stays clear (the next word is read ahead); a candidate that
// hits a used frame finds the last blocker, realigns past it and rereads. it then marks the
// run's words and posts the result; a free clears the run's words and posts the result. the
// bitmap's single read port gives one word per cycle. one item is worked on at a time; the
// next beat is taken while a finished result still waits on out_stall. WORD_BITS must be a
// power of two, which the block does not check.
module bitmap_contiguous_frame_allocator_top #(
	parameter int unsigned FRAMES    = bcfa_pkg::FRAMES_DEF,
	parameter int unsigned WORD_BITS = bcfa_pkg::WORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// base_frame write channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bcfa_pkg::FRM_W-1:0]  base_frame,
	// request channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [bcfa_pkg::OP_W-1:0]   op,
	input  logic [bcfa_pkg::CNT_W-1:0]  count,
	input  logic [bcfa_pkg::ALN_W-1:0]  align,
	input  logic [bcfa_pkg::FRM_W-1:0]  first_frame,
	// result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        status,
	output logic [bcfa_pkg::FRM_W-1:0]  frame,
	output logic [bcfa_pkg::CNT_W-1:0]  free_count
);
	import bcfa_pkg::*;

	localparam int unsigned NWORDS = (FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned WSH    = $clog2(WORD_BITS);
	localparam int unsigned AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	// offsets reach past the window by up to an alignment step plus a count
	localparam int unsigned OFFW   = $clog2(FRAMES + 16384) + 1;
	localparam int unsigned CNTW   = $clog2(FRAMES + 1);
	localparam int unsigned PW     = PHYS_W;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_START  = 7'b0000010,
		S_JUMP   = 7'b0000100,
		S_WAIT   = 7'b0001000,
		S_SCAN   = 7'b0010000,
		S_SWEEP  = 7'b0100000,
		S_FINISH = 7'b1000000
	} state_t;

	state_t st_q;

	logic [FRM_W-1:0]  base_q;
	logic [OP_W-1:0]   op_q;
	logic [CNT_W-1:0]  count_q;
	logic [ALN_W-1:0]  am_q;
	logic [FRM_W-1:0]  first_q;
	logic              fail_q;
	logic [OFFW-1:0]   rlo_q;     // run start offset (candidate while scanning)
	logic [OFFW-1:0]   rhi_q;     // run end offset, exclusive
	logic [AW-1:0]     cw_q;      // bitmap word under work
	logic [PW-1:0]     x_q;       // physical frame to realign from
	logic [CNTW-1:0]   ff_q;

	logic              out_valid_q;
	logic              status_q;
	logic [FRM_W-1:0]  frame_q;

	// bitmap store
	map_ctl_t          map_ctl;
	logic [AW-1:0]     map_addr;
	logic [WORD_BITS-1:0] map_mask;
	logic [WORD_BITS-1:0] map_rdata;
	logic              map_ready;

	logic              in_acc;
	logic              out_free;

	logic [OFFW-1:0]   hm1;
	logic [AW-1:0]     firstw;
	logic [AW-1:0]     lastw;
	logic [WSH-1:0]    lo_b;
	logic [WSH-1:0]    hl_b;
	logic [WORD_BITS-1:0] blk;
	logic [WSH-1:0]    tz;
	logic [WSH-1:0]    blk_pos;
	logic [OFFW-1:0]   blk_off;

	logic [PW-1:0]     am_ext;
	logic [PW-1:0]     al;
	logic [OFFW-1:0]   s_new;
	logic [OFFW-1:0]   e_new;
	logic              fits;

	logic [PW-1:0]     f_lo;
	logic [PW-1:0]     f_hi;
	logic [PW-1:0]     f_end;
	logic [PW-1:0]     w_end;
	logic [OFFW-1:0]   f_rlo;

	logic [OFFW-1:0]   delta;
	logic [OFFW:0]     ff_sum;

	function automatic logic [AW-1:0] word_of(input logic [OFFW-1:0] off);
		return AW'(off >> WSH);
	endfunction

	// msb-first bit mask of frame positions lo..hl inside one word
	function automatic logic [WORD_BITS-1:0] span_mask(input logic [WSH-1:0] lo,
	                                                   input logic [WSH-1:0] hl);
		logic [WORD_BITS-1:0] ones;
		ones = '1;
		return (ones >> lo) & (ones << (WSH'(WORD_BITS - 1) - hl));
	endfunction

	assign cfg_ready = 1'b1;
	assign in_stall  = ~((st_q == S_IDLE) & map_ready);
	assign in_acc    = in_valid & ~in_stall;
	assign out_free  = ~out_valid_q | ~out_stall;

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign frame      = frame_q;
	assign free_count = CNT_W'(ff_q);

	// word span of the current run
	assign hm1    = rhi_q - OFFW'(1);
	assign firstw = word_of(rlo_q);
	assign lastw  = word_of(hm1);
	assign lo_b   = (cw_q == firstw) ? rlo_q[WSH-1:0] : '0;
	assign hl_b   = (cw_q == lastw) ? hm1[WSH-1:0] : '1;

	assign map_mask = span_mask(lo_b, hl_b);
	assign blk      = map_rdata & map_mask;

	// last used frame inside the candidate's part of this word
	always_comb begin
		tz = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (blk[i]) begin
				tz = WSH'(i);
			end
		end
	end
	assign blk_pos = WSH'(WORD_BITS - 1) - tz;
	assign blk_off = (OFFW'(cw_q) << WSH) | OFFW'(blk_pos);

	// next aligned candidate at or above x_q
	assign am_ext = PW'(am_q);
	assign al     = (x_q + am_ext) & ~am_ext;
	assign s_new  = OFFW'(al - PW'(base_q));
	assign e_new  = s_new + OFFW'(count_q);
	assign fits   = (e_new <= OFFW'(FRAMES));

	// free: clip the run to the window
	assign f_end = PW'(first_q) + PW'(count_q);
	assign w_end = PW'(base_q) + PW'(FRAMES);
	assign f_lo  = (PW'(first_q) < PW'(base_q)) ? PW'(base_q) : PW'(first_q);
	assign f_hi  = (f_end > w_end) ? w_end : f_end;
	assign f_rlo = OFFW'(f_lo - PW'(base_q));

	// counter update, saturating both ways
	assign delta  = rhi_q - rlo_q;
	assign ff_sum = (OFFW + 1)'(ff_q) + (OFFW + 1)'(delta);

	// memory requests: read ahead one word while a clean run is walked
	always_comb begin
		map_ctl          = '0;
		map_ctl.set_bits = (op_q == OP_ALLOC);
		map_addr         = cw_q;
		unique case (st_q)
			S_WAIT: begin
				map_ctl.rd = 1'b1;
			end
			S_SCAN: begin
				map_ctl.rd = (cw_q != lastw);
				map_addr   = cw_q + AW'(1);
			end
			S_SWEEP: begin
				map_ctl.upd = 1'b1;
			end
			default: begin
				map_ctl.rd = 1'b0;
			end
		endcase
	end

	bcfa_map #(
		.DEPTH (NWORDS),
		.WIDTH (WORD_BITS)
	) u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (map_ctl),
		.addr   (map_addr),
		.mask   (map_mask),
		.rdata  (map_rdata),
		.ready  (map_ready)
	);

	// item payload and run bookkeeping
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q    <= op;
			count_q <= count;
			am_q    <= align_mask(align);
			first_q <= first_frame;
		end
		unique case (st_q)
			S_START: begin
				fail_q <= 1'b0;
				x_q    <= PW'(base_q);
				if (op_q == OP_FREE) begin
					if (f_lo < f_hi) begin
						rlo_q <= f_rlo;
						rhi_q <= OFFW'(f_hi - PW'(base_q));
						cw_q  <= word_of(f_rlo);
					end else begin
						rlo_q <= '0;
						rhi_q <= '0;
					end
				end
			end
			S_JUMP: begin
				if (count_q == '0) begin
					// empty run: report the first aligned frame, mark nothing
					rlo_q <= s_new;
					rhi_q <= s_new;
				end else if (!fits) begin
					fail_q <= 1'b1;
					rlo_q  <= '0;
					rhi_q  <= '0;
				end else begin
					rlo_q <= s_new;
					rhi_q <= e_new;
					cw_q  <= word_of(s_new);
				end
			end
			S_SCAN: begin
				if (blk != '0) begin
					x_q <= PW'(base_q) + PW'(blk_off) + PW'(1);
				end else if (cw_q == lastw) begin
					cw_q <= firstw;
				end else begin
					cw_q <= cw_q + AW'(1);
				end
			end
			S_SWEEP: begin
				cw_q <= cw_q + AW'(1);
			end
			default: begin
				x_q <= x_q;
			end
		endcase
		if (st_q == S_FINISH && out_free) begin
			status_q <= fail_q ? STAT_NOMEM : STAT_OK;
			frame_q  <= (op_q == OP_ALLOC && !fail_q) ?
			            FRM_W'(PW'(base_q) + PW'(rlo_q)) : '0;
		end
	end

	// sequencer, counter, config and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			base_q      <= '0;
			ff_q        <= CNTW'(FRAMES);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				base_q <= base_frame;
			end
			// a new result replaces one taken at the same edge
			if (st_q == S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (in_acc) begin
						st_q <= S_START;
					end
				end
				S_START: begin
					if (op_q == OP_ALLOC) begin
						st_q <= S_JUMP;
					end else if (f_lo < f_hi) begin
						st_q <= S_SWEEP;
					end else begin
						st_q <= S_FINISH;
					end
				end
				S_JUMP: begin
					if (count_q == '0 || !fits) begin
						st_q <= S_FINISH;
					end else begin
						st_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					st_q <= S_SCAN;
				end
				S_SCAN: begin
					if (blk != '0) begin
						st_q <= S_JUMP;
					end else if (cw_q == lastw) begin
						st_q <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					if (cw_q == lastw) begin
						st_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						st_q <= S_IDLE;
						if (op_q == OP_ALLOC) begin
							ff_q <= (OFFW'(ff_q) > delta) ? CNTW'(OFFW'(ff_q) - delta) : '0;
						end else begin
							ff_q <= (ff_sum > (OFFW + 1)'(FRAMES)) ?
							        CNTW'(FRAMES) : CNTW'(ff_sum);
						end
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// counter never leaves its range
	a_ff_range: assert property (@(posedge clk) disable iff (!arst_n)
		OFFW'(ff_q) <= OFFW'(FRAMES))
		else $error("free counter above window size");

	// scan never walks past the last word of its candidate run
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_SCAN) |-> (cw_q <= lastw && cw_q >= firstw))
		else $error("scan word outside candidate run");

	// marking and clearing stay on a non-empty run inside the window
	a_sweep_run: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_SWEEP) |-> (rlo_q < rhi_q && rhi_q <= OFFW'(FRAMES)))
		else $error("sweep over an empty or out-of-window run");

	// a failed allocation reports frame zero
	a_fail_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STAT_NOMEM) |-> (frame == '0))
		else $error("failed allocation with non-zero frame");

endmodule

// ----- sv/bcfa_map.sv -----
module bcfa_map #(
	parameter int unsigned DEPTH = 128,
	parameter int unsigned WIDTH = 32,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bcfa_pkg::map_ctl_t  ctl,
	input  logic [AW-1:0]       addr,
	input  logic [WIDTH-1:0]    mask,
	output logic [WIDTH-1:0]    rdata,
	output logic                ready
);
	import bcfa_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];

	logic             clr_busy_q;
	logic [AW-1:0]    clr_idx_q;

	logic             upd_s1;
	logic             set_s1;
	logic [AW-1:0]    addr_s1;
	logic [WIDTH-1:0] mask_s1;
	logic [WIDTH-1:0] raw_s1;
	logic             fwd_s1;
	logic [WIDTH-1:0] fwd_data_s1;

	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [WIDTH-1:0] wr_data;
	logic [WIDTH-1:0] merged;
	logic             rd_any;

	assign rd_any = ctl.rd | ctl.upd;
	assign ready  = ~clr_busy_q;

	// write in flight to the word being read this cycle wins over the array
	assign rdata  = fwd_s1 ? fwd_data_s1 : raw_s1;
	assign merged = set_s1 ? (rdata | mask_s1) : (rdata & ~mask_s1);

	assign wr_en   = clr_busy_q | upd_s1;
	assign wr_addr = clr_busy_q ? clr_idx_q : addr_s1;
	assign wr_data = clr_busy_q ? '0 : merged;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_any) begin
			raw_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		set_s1      <= ctl.set_bits;
		addr_s1     <= addr;
		mask_s1     <= mask;
		fwd_data_s1 <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
			upd_s1     <= 1'b0;
			fwd_s1     <= 1'b0;
		end else begin
			upd_s1 <= ctl.upd;
			fwd_s1 <= rd_any & wr_en & (wr_addr == addr);
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + AW'(1);
				if (clr_idx_q == AW'(DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
		end
	end

endmodule
